// ----- src/serial_command_clock_decoder_macros.svh -----
// assertion macros for the serial command clock decoder
// used by the top level only; expects clk and rst_n in scope
`ifndef SERIAL_COMMAND_CLOCK_DECODER_MACROS_SVH
`define SERIAL_COMMAND_CLOCK_DECODER_MACROS_SVH

// same-cycle implication, checked outside reset
`define SCD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("scd check failed: same cycle");

// next-cycle implication, checked outside reset
`define SCD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("scd check failed: next cycle");

`endif

// ----- src/scd_pkg.sv -----
// shared types, codes and constants for the serial command clock decoder
// no dependencies
package scd_pkg;

  localparam int TEXT_CAP   = 20;
  localparam int LINE_WIDTH = 20;
  localparam int CNT_W      = $clog2(TEXT_CAP);
  localparam int COL_W      = $clog2(LINE_WIDTH);
  localparam int IDX_W      = 5;
  localparam int CMP_W      = (CNT_W > IDX_W) ? CNT_W : IDX_W;

  // command codes
  localparam logic [1:0] CMD_BYTE = 2'd0;
  localparam logic [1:0] CMD_TICK = 2'd1;
  localparam logic [1:0] CMD_READ = 2'd2;

  // serial command bytes
  localparam logic [7:0] BYTE_CLOCK = 8'd60;   // '<'
  localparam logic [7:0] BYTE_TEXT  = 8'd123;  // '{'
  localparam logic [7:0] BYTE_CLEAR = 8'd62;   // '>'
  localparam logic [7:0] BYTE_END   = 8'd125;  // '}'
  localparam logic [7:0] TONE_MAX   = 8'd7;

  // ascii digits
  localparam logic [7:0] ASCII_0 = 8'd48;
  localparam logic [7:0] ASCII_2 = 8'd50;
  localparam logic [7:0] ASCII_3 = 8'd51;
  localparam logic [7:0] ASCII_5 = 8'd53;
  localparam logic [7:0] ASCII_9 = 8'd57;

  localparam logic [2:0] SET_DIGITS = 3'd6;

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_CLOCK,
    MODE_TEXT
  } mode_t;

  typedef enum logic [2:0] {
    EV_NONE,
    EV_CHAR,
    EV_CLEAR,
    EV_TONE,
    EV_COMMIT,
    EV_TIME,
    EV_READ
  } event_t;

  typedef enum logic [2:0] {
    DIG_HT,
    DIG_HU,
    DIG_MT,
    DIG_MU,
    DIG_ST,
    DIG_SU
  } digit_sel_t;

  typedef struct packed {
    logic       clear;
    logic       capture;
    logic [7:0] data;
  } text_ctl_t;

  typedef struct packed {
    logic       tick;
    logic       set;
    digit_sel_t sel;
    logic [7:0] data;
  } time_ctl_t;

  typedef struct packed {
    logic [7:0] ht;
    logic [7:0] hu;
    logic [7:0] mt;
    logic [7:0] mu;
    logic [7:0] st;
    logic [7:0] su;
  } clock_digits_t;

  typedef struct packed {
    event_t     ev;
    logic [4:0] column;
    logic [7:0] char_code;
    logic [2:0] tone;
    logic [4:0] text_length;
  } dec_res_t;

endpackage

// ----- src/serial_command_clock_decoder.sv -----
// top level of the serial command clock decoder: input and result registers
// depends on scd_pkg, scd_decode, scd_text_store, scd_time and the macro header
//
//  channel  | dir | handshake          | payload
//  ---------+-----+--------------------+--------------------------------------
//  in_      | in  | in_tvalid/tready   | tuser cmd, tdata rx_byte, text_index
//  out_     | out | out_tvalid/tready  | tuser event, tdata result fields
//
// one word per cycle while out_tready holds high; an accepted word waits in the
// input register, and its result word is registered in the result register
// the single decode pass between those two registers is combinational
// rst_n is synchronous: mode idle, counts zero, clock 23:59:00, no stored text
// a stalled result holds in the output register while one more word waits
// in the input register; in_tready falls only when both are full
`include "serial_command_clock_decoder_macros.svh"

module serial_command_clock_decoder import scd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [1:0]  in_tuser,   // cmd
  input  logic [15:0] in_tdata,   // rx_byte[7:0], text_index[12:8], zero pad
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [2:0]  out_tuser,  // event_res
  // column[4:0], char_code[12:5], tone[15:13], text_length[20:16],
  // hour_tens[28:21], hour_units[36:29], minute_tens[44:37],
  // minute_units[52:45], second_tens[60:53], second_units[68:61], zero pad
  output logic [71:0] out_tdata
);

  // input register stage
  logic             s1_valid_r;
  logic [1:0]       s1_cmd_r;
  logic [7:0]       s1_byte_r;
  logic [IDX_W-1:0] s1_idx_r;
  logic             s1_fire;
  logic             in_fire;

  // result register stage
  logic        out_valid_r;
  logic [2:0]  out_user_r;
  logic [71:0] out_data_r;
  logic [71:0] out_data_nxt;

  text_ctl_t        text_ctl;
  time_ctl_t        time_ctl;
  dec_res_t         res;
  clock_digits_t    digits;
  clock_digits_t    shown;
  logic [7:0]       rd_data;
  logic [CNT_W-1:0] text_count;

  // decode runs whenever the result register is free or being drained
  assign s1_fire   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_fire;
  assign in_fire   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_cmd_r  <= in_tuser;
      s1_byte_r <= in_tdata[7:0];
      s1_idx_r  <= in_tdata[12:8];
    end
  end

  scd_decode u_decode (
    .clk        (clk),
    .rst_n      (rst_n),
    .fire       (s1_fire),
    .cmd        (s1_cmd_r),
    .rx_byte    (s1_byte_r),
    .rd_data    (rd_data),
    .text_count (text_count),
    .text_ctl   (text_ctl),
    .time_ctl   (time_ctl),
    .res        (res)
  );

  scd_text_store u_text (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (s1_fire),
    .ctl     (text_ctl),
    .rd_idx  (s1_idx_r),
    .rd_data (rd_data),
    .count   (text_count)
  );

  scd_time u_time (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (s1_fire),
    .ctl    (time_ctl),
    .digits (digits)
  );

  // digits are reported as they stood before the advance, only on a tick
  assign shown = (res.ev == EV_TIME) ? digits : '0;

  assign out_data_nxt = {3'b000, shown.su, shown.st, shown.mu, shown.mt, shown.hu,
                         shown.ht, res.text_length, res.tone, res.char_code,
                         res.column};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_user_r <= res.ev;
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_user_r;
  assign out_tdata  = out_data_r;

  // an empty result register must never block the input side
  `SCD_ASSERT_NOW(a_ready_when_drained, !out_valid_r, in_tready)
  // a decoded word always lands in the result register
  `SCD_ASSERT_NEXT(a_fire_gives_result, s1_fire, out_tvalid)
  // the fill count never reaches the store depth
  `SCD_ASSERT_NOW(a_count_bound, 1'b1, 32'(text_count) < 32'(TEXT_CAP))
  // displayed characters only ever land on the line
  `SCD_ASSERT_NOW(a_column_bound, out_tvalid && (out_tuser == EV_CHAR), 32'(out_tdata[4:0]) < 32'(LINE_WIDTH))

endmodule

// ----- src/scd_text_store.sv -----
// text capture store with fill count and guarded read port
// depends on scd_pkg
module scd_text_store import scd_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             fire,
  input  text_ctl_t        ctl,
  input  logic [IDX_W-1:0] rd_idx,
  output logic [7:0]       rd_data,
  output logic [CNT_W-1:0] count
);

  logic [7:0]       store_r [TEXT_CAP];
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic             room;
  logic             wr_en;
  logic             hit;

  assign room  = count_r < CNT_W'(TEXT_CAP - 1);
  assign wr_en = fire && ctl.capture && room;

  always_comb begin
    count_nxt = count_r;
    if (fire && ctl.clear) begin
      count_nxt = '0;
    end else if (wr_en) begin
      count_nxt = count_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store_r[count_r] <= ctl.data;
    end
  end

  // entries at or past the count read as zero
  assign hit     = CMP_W'(rd_idx) < CMP_W'(count_r);
  assign rd_data = hit ? store_r[CNT_W'(rd_idx)] : 8'd0;
  assign count   = count_r;

endmodule

// ----- src/scd_time.sv -----
// ascii time-of-day digits with load and one-second advance
// depends on scd_pkg
module scd_time import scd_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          fire,
  input  time_ctl_t     ctl,
  output clock_digits_t digits
);

  clock_digits_t digits_r;
  clock_digits_t digits_nxt;
  clock_digits_t adv;
  logic          c_su;
  logic          c_st;
  logic          c_mu;
  logic          c_mt;
  logic          day_wrap;

  // carry chain on raw codes, 8-bit wrap
  always_comb begin
    adv      = digits_r;
    c_su     = digits_r.su == ASCII_9;
    c_st     = c_su && (digits_r.st == ASCII_5);
    c_mu     = c_st && (digits_r.mu == ASCII_9);
    c_mt     = c_mu && (digits_r.mt == ASCII_5);
    day_wrap = (digits_r.hu == ASCII_3) && (digits_r.ht == ASCII_2);
    adv.su   = c_su ? ASCII_0 : digits_r.su + 8'd1;
    if (c_su) begin
      adv.st = (digits_r.st == ASCII_5) ? ASCII_0 : digits_r.st + 8'd1;
    end
    if (c_st) begin
      adv.mu = (digits_r.mu == ASCII_9) ? ASCII_0 : digits_r.mu + 8'd1;
    end
    if (c_mu) begin
      adv.mt = (digits_r.mt == ASCII_5) ? ASCII_0 : digits_r.mt + 8'd1;
    end
    if (c_mt) begin
      if (day_wrap) begin
        adv.ht = ASCII_0;
        adv.hu = ASCII_0;
      end else if (digits_r.hu == ASCII_9) begin
        adv.ht = digits_r.ht + 8'd1;
        adv.hu = ASCII_0;
      end else begin
        adv.hu = digits_r.hu + 8'd1;
      end
    end
  end

  always_comb begin
    digits_nxt = digits_r;
    if (fire && ctl.set) begin
      unique case (ctl.sel)
        DIG_HT:  digits_nxt.ht = ctl.data;
        DIG_HU:  digits_nxt.hu = ctl.data;
        DIG_MT:  digits_nxt.mt = ctl.data;
        DIG_MU:  digits_nxt.mu = ctl.data;
        DIG_ST:  digits_nxt.st = ctl.data;
        DIG_SU:  digits_nxt.su = ctl.data;
        default: digits_nxt = digits_r;
      endcase
    end else if (fire && ctl.tick) begin
      digits_nxt = adv;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      digits_r.ht <= ASCII_2;
      digits_r.hu <= ASCII_3;
      digits_r.mt <= ASCII_5;
      digits_r.mu <= ASCII_9;
      digits_r.st <= ASCII_0;
      digits_r.su <= ASCII_0;
    end else begin
      digits_r <= digits_nxt;
    end
  end

  assign digits = digits_r;

endmodule

// ----- src/scd_decode.sv -----
// command decoder: mode machine, clock-set counter and display column
// depends on scd_pkg
module scd_decode import scd_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             fire,
  input  logic [1:0]       cmd,
  input  logic [7:0]       rx_byte,
  input  logic [7:0]       rd_data,
  input  logic [CNT_W-1:0] text_count,
  output text_ctl_t        text_ctl,
  output time_ctl_t        time_ctl,
  output dec_res_t         res
);

  mode_t            mode_r;
  mode_t            mode_nxt;
  logic [2:0]       set_count_r;
  logic [2:0]       set_count_nxt;
  logic [COL_W-1:0] col_r;
  logic [COL_W-1:0] col_nxt;

  logic is_byte;
  logic b_clock;
  logic b_text;
  logic b_clear;
  logic b_tone;
  logic b_cmd;

  assign is_byte = cmd == CMD_BYTE;
  assign b_clock = rx_byte == BYTE_CLOCK;
  assign b_text  = rx_byte == BYTE_TEXT;
  assign b_clear = rx_byte == BYTE_CLEAR;
  assign b_tone  = rx_byte <= TONE_MAX;
  assign b_cmd   = b_clock || b_text || b_clear || b_tone;

  // next state
  always_comb begin
    mode_nxt      = mode_r;
    set_count_nxt = set_count_r;
    col_nxt       = col_r;
    if (is_byte) begin
      if (b_clock) begin
        mode_nxt      = MODE_CLOCK;
        set_count_nxt = SET_DIGITS;
      end else if (b_text) begin
        mode_nxt = MODE_TEXT;
      end else if (b_clear) begin
        mode_nxt = MODE_IDLE;
        col_nxt  = '0;
      end else if (b_tone) begin
        mode_nxt = MODE_IDLE;
      end else begin
        unique case (mode_r)
          MODE_CLOCK: begin
            if (set_count_r <= 3'd1) begin
              set_count_nxt = '0;
              mode_nxt      = MODE_IDLE;
            end else begin
              set_count_nxt = set_count_r - 3'd1;
            end
          end
          MODE_TEXT: begin
            if (rx_byte == BYTE_END) begin
              mode_nxt = MODE_IDLE;
            end
          end
          default: begin
            col_nxt = (col_r == COL_W'(LINE_WIDTH - 1)) ? '0 : col_r + 1'b1;
          end
        endcase
      end
    end
  end

  // outputs
  always_comb begin
    res      = '0;
    res.ev   = EV_NONE;
    text_ctl = '0;
    time_ctl = '0;
    time_ctl.sel = DIG_SU;
    unique case (cmd)
      CMD_BYTE: begin
        if (b_text) begin
          text_ctl.clear = 1'b1;
        end else if (b_clear) begin
          res.ev = EV_CLEAR;
        end else if (b_tone) begin
          res.ev   = EV_TONE;
          res.tone = rx_byte[2:0];
        end else if (!b_cmd) begin
          unique case (mode_r)
            MODE_CLOCK: begin
              time_ctl.set  = 1'b1;
              time_ctl.data = rx_byte;
              unique case (set_count_r)
                3'd6:    time_ctl.sel = DIG_HT;
                3'd5:    time_ctl.sel = DIG_HU;
                3'd4:    time_ctl.sel = DIG_MT;
                3'd3:    time_ctl.sel = DIG_MU;
                3'd2:    time_ctl.sel = DIG_ST;
                default: time_ctl.sel = DIG_SU;
              endcase
            end
            MODE_TEXT: begin
              if (rx_byte == BYTE_END) begin
                res.ev          = EV_COMMIT;
                res.text_length = 5'(text_count);
              end else begin
                text_ctl.capture = 1'b1;
                text_ctl.data    = rx_byte;
              end
            end
            default: begin
              res.ev        = EV_CHAR;
              res.column    = 5'(col_r);
              res.char_code = rx_byte;
            end
          endcase
        end
      end
      CMD_TICK: begin
        res.ev        = EV_TIME;
        time_ctl.tick = 1'b1;
      end
      CMD_READ: begin
        res.ev        = EV_READ;
        res.char_code = rd_data;
      end
      default: res.ev = EV_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_IDLE;
      set_count_r <= '0;
      col_r       <= '0;
    end else if (fire) begin
      mode_r      <= mode_nxt;
      set_count_r <= set_count_nxt;
      col_r       <= col_nxt;
    end
  end

endmodule

// ----- test/tb.sv -----
// self-checking testbench for serial_command_clock_decoder
// needs scd_pkg and the decoder rtl; drives stream words and checks every result word
`timescale 1ns / 1ps

module tb;
  import scd_pkg::*;

  // spare command code, decoded as no event
  localparam logic [1:0] CMD_SPARE  = 2'd3;
  // the clock advance parks a digit one below '0' before the increment
  localparam logic [7:0] BELOW_ZERO = ASCII_0 - 8'd1;
  localparam int         IDLE_LIMIT = 2000;
  localparam int         RANDOM_WORDS = 750;

  // one expected result word, in the order of the output fields
  typedef struct packed {
    event_t        ev;
    logic [4:0]    column;
    logic [7:0]    char_code;
    logic [2:0]    tone;
    logic [4:0]    text_length;
    clock_digits_t digits;
  } decoder_result_t;

  // one row of the directed script; typed rows carry a hand-written result
  typedef struct {
    logic [1:0]      cmd;
    logic [7:0]      rx;
    logic [4:0]      idx;
    bit              typed;
    decoder_result_t want;
  } script_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [1:0]  in_tuser = '0;    // cmd
  logic [15:0] in_tdata = '0;    // rx_byte[7:0], text_index[12:8], zero pad
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [2:0]  out_tuser;        // event_res
  // column[4:0], char_code[12:5], tone[15:13], text_length[20:16],
  // hour_tens[28:21] .. second_units[68:61], zero pad
  logic [71:0] out_tdata;

  serial_command_clock_decoder dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tuser (out_tuser),
    .out_tdata (out_tdata)
  );

  // 20 ns clock
  initial begin
    forever #10 clk = ~clk;
  end

  // predictor state, a private copy of the decoder's
  mode_t         dec_mode = MODE_IDLE;
  logic [2:0]    digits_left = '0;
  logic [7:0]    text_mem [0:TEXT_CAP-1];
  logic [4:0]    text_len = '0;
  logic [4:0]    cursor = '0;
  clock_digits_t shown = '{ASCII_2, ASCII_3, ASCII_5, ASCII_9, ASCII_0, ASCII_0};

  decoder_result_t pending_results[$];
  script_row_t     script[$];
  int              errors = 0;
  int              random_sent = 0;

  // advance the clock by one second on raw codes, carries ripple upward
  function automatic void tick_clock();
    if (shown.su == ASCII_9) begin
      if (shown.st == ASCII_5) begin
        if (shown.mu == ASCII_9) begin
          if (shown.mt == ASCII_5) begin
            // 23 rolls over to 00, x9 carries into the hour tens
            if (shown.hu == ASCII_3 && shown.ht == ASCII_2) begin
              shown.ht = ASCII_0;
              shown.hu = BELOW_ZERO;
            end else if (shown.hu == ASCII_9) begin
              shown.hu = BELOW_ZERO;
              shown.ht = shown.ht + 8'd1;
            end
            shown.mt = BELOW_ZERO;
            shown.hu = shown.hu + 8'd1;
          end
          shown.mu = BELOW_ZERO;
          shown.mt = shown.mt + 8'd1;
        end
        shown.st = BELOW_ZERO;
        shown.mu = shown.mu + 8'd1;
      end
      shown.su = BELOW_ZERO;
      shown.st = shown.st + 8'd1;
    end
    shown.su = shown.su + 8'd1;
  endfunction

  // expected result of one accepted word; updates the predictor state
  function automatic decoder_result_t predict_step(input logic [1:0] cmd,
                                                   input logic [7:0] rx,
                                                   input logic [4:0] idx);
    decoder_result_t r;
    r = '0;
    r.ev = EV_NONE;
    case (cmd)
      CMD_BYTE: begin
        // command bytes win in every mode and abandon a setting or capture
        if (rx == BYTE_CLOCK) begin
          dec_mode = MODE_CLOCK;
          digits_left = SET_DIGITS;
        end else if (rx == BYTE_TEXT) begin
          dec_mode = MODE_TEXT;
          text_len = '0;
        end else if (rx == BYTE_CLEAR) begin
          dec_mode = MODE_IDLE;
          cursor = '0;
          r.ev = EV_CLEAR;
        end else if (rx <= TONE_MAX) begin
          dec_mode = MODE_IDLE;
          r.tone = rx[2:0];
          r.ev = EV_TONE;
        end else if (dec_mode == MODE_CLOCK) begin
          // raw digits, hour tens first
          case (digits_left)
            3'd6:    shown.ht = rx;
            3'd5:    shown.hu = rx;
            3'd4:    shown.mt = rx;
            3'd3:    shown.mu = rx;
            3'd2:    shown.st = rx;
            default: shown.su = rx;
          endcase
          if (digits_left <= 3'd1) begin
            digits_left = '0;
            dec_mode = MODE_IDLE;
          end else begin
            digits_left = digits_left - 3'd1;
          end
        end else if (dec_mode == MODE_TEXT) begin
          if (rx == BYTE_END) begin
            dec_mode = MODE_IDLE;
            r.text_length = text_len;
            r.ev = EV_COMMIT;
          end else if (text_len < TEXT_CAP - 1) begin
            // characters past the cap are dropped
            text_mem[text_len] = rx;
            text_len = text_len + 5'd1;
          end
        end else begin
          r.column = cursor;
          r.char_code = rx;
          r.ev = EV_CHAR;
          cursor = (cursor < LINE_WIDTH - 1) ? cursor + 5'd1 : 5'd0;
        end
      end
      CMD_TICK: begin
        // report the digits as shown, then advance
        r.digits = shown;
        r.ev = EV_TIME;
        tick_clock();
      end
      CMD_READ: begin
        // past the committed length the read gives zero
        if (idx < text_len && idx < TEXT_CAP) r.char_code = text_mem[idx];
        r.ev = EV_READ;
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic decoder_result_t outcome(input event_t ev, input logic [4:0] column,
                                              input logic [7:0] code, input logic [2:0] tone,
                                              input logic [4:0] len, input clock_digits_t d);
    decoder_result_t r;
    r.ev = ev;
    r.column = column;
    r.char_code = code;
    r.tone = tone;
    r.text_length = len;
    r.digits = d;
    return r;
  endfunction

  function automatic void add_row(input logic [1:0] cmd, input logic [7:0] rx,
                                  input logic [4:0] idx, input bit typed,
                                  input decoder_result_t want);
    script_row_t row;
    row.cmd = cmd;
    row.rx = rx;
    row.idx = idx;
    row.typed = typed;
    row.want = want;
    script.push_back(row);
  endfunction

  // gap length: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  // a byte that is shown or stored, never a command byte; '}' only when no_end is clear
  function automatic logic [7:0] plain_byte(input bit no_end);
    logic [7:0] b;
    do begin
      b = 8'($urandom_range(8, 255));
    end while (b == BYTE_CLOCK || b == BYTE_TEXT || b == BYTE_CLEAR ||
               (no_end && b == BYTE_END));
    return b;
  endfunction

  // offer one word after an optional gap, wait for the handshake,
  // then queue its expected result
  bit calm = 1'b0;

  task automatic push_word(input logic [1:0] cmd, input logic [7:0] rx,
                           input logic [4:0] idx, input bit typed,
                           input decoder_result_t want);
    int gap;
    decoder_result_t predicted;
    gap = calm ? 0 : pick_gap();
    repeat (gap) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser <= cmd;
    in_tdata <= {3'b000, idx, rx};
    do @(posedge clk); while (!in_tready);
    predicted = predict_step(cmd, rx, idx);
    pending_results.push_back(typed ? want : predicted);
  endtask

  task automatic send(input logic [1:0] cmd, input logic [7:0] rx, input logic [4:0] idx);
    push_word(cmd, rx, idx, 1'b0, '0);
    random_sent++;
  endtask

  // hold the sender off until every queued result has come out
  task automatic drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic check_field(input string name, input logic [7:0] want,
                             input logic [7:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  // result side: compare each accepted word with the oldest expectation
  always @(posedge clk) begin
    decoder_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $error("result word with no expectation: event %0d", out_tuser);
        errors++;
      end else begin
        want = pending_results.pop_front();
        check_field("event_res", 8'(want.ev), 8'(out_tuser));
        check_field("column", 8'(want.column), 8'(out_tdata[4:0]));
        check_field("char_code", want.char_code, out_tdata[12:5]);
        check_field("tone", 8'(want.tone), 8'(out_tdata[15:13]));
        check_field("text_length", 8'(want.text_length), 8'(out_tdata[20:16]));
        check_field("hour_tens", want.digits.ht, out_tdata[28:21]);
        check_field("hour_units", want.digits.hu, out_tdata[36:29]);
        check_field("minute_tens", want.digits.mt, out_tdata[44:37]);
        check_field("minute_units", want.digits.mu, out_tdata[52:45]);
        check_field("second_tens", want.digits.st, out_tdata[60:53]);
        check_field("second_units", want.digits.su, out_tdata[68:61]);
      end
    end
  end

  // result side back-pressure: calm stretches, short stalls, a few long ones
  initial begin
    int stall_left;
    int phase_left;
    bit rx_calm;
    stall_left = 0;
    phase_left = 0;
    rx_calm = 1'b0;
    forever begin
      @(negedge clk);
      if (phase_left == 0) begin
        phase_left = $urandom_range(50, 200);
        rx_calm = ($urandom_range(0, 3) == 0);
      end
      phase_left--;
      if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else begin
        out_tready <= 1'b1;
        if (!rx_calm && $urandom_range(0, 99) < 25) stall_left = pick_gap();
      end
    end
  end

  // watchdog: too many cycles without a handshake on either side
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet = 0;
      else quiet++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  // stimulus
  initial begin
    int kind;
    int n;
    logic [7:0] d [0:5];
    foreach (text_mem[i]) text_mem[i] = '0;

    // synchronous reset held low, then released on a falling clock edge
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed script: reset values, extremes and the special cases
    add_row(CMD_TICK, 8'd0, 5'd0, 1'b1, outcome(EV_TIME, 5'd0, 8'd0, 3'd0, 5'd0,
            '{ASCII_2, ASCII_3, ASCII_5, ASCII_9, ASCII_0, ASCII_0}));
    add_row(CMD_READ, 8'd0, 5'd0, 1'b1, outcome(EV_READ, 5'd0, 8'd0, 3'd0, 5'd0, '0));
    add_row(CMD_BYTE, 8'd0, 5'd0, 1'b1, outcome(EV_TONE, 5'd0, 8'd0, 3'd0, 5'd0, '0));
    add_row(CMD_BYTE, TONE_MAX, 5'd0, 1'b1, outcome(EV_TONE, 5'd0, 8'd0, 3'd7, 5'd0, '0));
    add_row(CMD_BYTE, 8'd8, 5'd0, 1'b1, outcome(EV_CHAR, 5'd0, 8'd8, 3'd0, 5'd0, '0));
    add_row(CMD_BYTE, 8'd255, 5'd0, 1'b1, outcome(EV_CHAR, 5'd1, 8'd255, 3'd0, 5'd0, '0));
    add_row(CMD_BYTE, BYTE_CLEAR, 5'd0, 1'b1, outcome(EV_CLEAR, 5'd0, 8'd0, 3'd0, 5'd0, '0));
    // closing brace while idle is just a character
    add_row(CMD_BYTE, BYTE_END, 5'd0, 1'b1,
            outcome(EV_CHAR, 5'd0, BYTE_END, 3'd0, 5'd0, '0));
    // set 23:59:59 and watch it roll over to midnight
    add_row(CMD_BYTE, BYTE_CLOCK, 5'd0, 1'b1, '0);
    add_row(CMD_BYTE, ASCII_2, 5'd0, 1'b1, '0);
    add_row(CMD_BYTE, ASCII_3, 5'd0, 1'b1, '0);
    add_row(CMD_BYTE, ASCII_5, 5'd0, 1'b1, '0);
    add_row(CMD_BYTE, ASCII_9, 5'd0, 1'b1, '0);
    add_row(CMD_BYTE, ASCII_5, 5'd0, 1'b1, '0);
    add_row(CMD_BYTE, ASCII_9, 5'd0, 1'b1, '0);
    add_row(CMD_TICK, 8'd0, 5'd0, 1'b1, outcome(EV_TIME, 5'd0, 8'd0, 3'd0, 5'd0,
            '{ASCII_2, ASCII_3, ASCII_5, ASCII_9, ASCII_5, ASCII_9}));
    add_row(CMD_TICK, 8'd0, 5'd0, 1'b1, outcome(EV_TIME, 5'd0, 8'd0, 3'd0, 5'd0,
            '{ASCII_0, ASCII_0, ASCII_0, ASCII_0, ASCII_0, ASCII_0}));
    // one-character text, read back inside and beyond its length
    add_row(CMD_BYTE, BYTE_TEXT, 5'd0, 1'b1, '0);
    add_row(CMD_BYTE, 8'd120, 5'd0, 1'b1, '0);
    add_row(CMD_BYTE, BYTE_END, 5'd0, 1'b1, outcome(EV_COMMIT, 5'd0, 8'd0, 3'd0, 5'd1, '0));
    add_row(CMD_READ, 8'd0, 5'd0, 1'b1, outcome(EV_READ, 5'd0, 8'd120, 3'd0, 5'd0, '0));
    add_row(CMD_READ, 8'd0, 5'd31, 1'b1, outcome(EV_READ, 5'd0, 8'd0, 3'd0, 5'd0, '0));
    add_row(CMD_SPARE, 8'd255, 5'd31, 1'b1, '0);
    // a tone abandons a capture, a clear abandons a clock setting
    add_row(CMD_BYTE, BYTE_TEXT, 5'd0, 1'b0, '0);
    add_row(CMD_BYTE, 8'd5, 5'd0, 1'b0, '0);
    add_row(CMD_BYTE, BYTE_CLOCK, 5'd0, 1'b0, '0);
    add_row(CMD_BYTE, BYTE_CLEAR, 5'd0, 1'b0, '0);
    foreach (script[i])
      push_word(script[i].cmd, script[i].rx, script[i].idx, script[i].typed, script[i].want);
    drain();

    // random part: mostly well-formed sequences, some noise and broken ones
    while (random_sent < RANDOM_WORDS) begin
      calm = ($urandom_range(0, 4) == 0);
      kind = $urandom_range(0, 99);
      if (kind < 20) begin
        // clock setting, usually digits close to a carry, then ticks
        d[0] = 8'($urandom_range(ASCII_0, ASCII_2));
        d[1] = 8'((d[0] == ASCII_2) ? $urandom_range(ASCII_0, ASCII_3)
                                    : $urandom_range(ASCII_0, ASCII_9));
        d[2] = $urandom_range(0, 1) ? ASCII_5 : 8'($urandom_range(ASCII_0, ASCII_5));
        d[3] = $urandom_range(0, 1) ? ASCII_9 : 8'($urandom_range(ASCII_0, ASCII_9));
        d[4] = $urandom_range(0, 1) ? ASCII_5 : 8'($urandom_range(ASCII_0, ASCII_5));
        d[5] = 8'($urandom_range(ASCII_5, ASCII_9));
        if ($urandom_range(0, 9) == 0)
          foreach (d[i]) d[i] = plain_byte(1'b0);
        send(CMD_BYTE, BYTE_CLOCK, 5'($urandom_range(0, 31)));
        foreach (d[i]) send(CMD_BYTE, d[i], 5'($urandom_range(0, 31)));
        repeat ($urandom_range(1, 12)) send(CMD_TICK, 8'($urandom_range(0, 255)), 5'd0);
      end else if (kind < 45) begin
        // text capture, sometimes past the cap, then reads
        n = ($urandom_range(0, 3) == 0) ? $urandom_range(19, 26) : $urandom_range(0, 18);
        send(CMD_BYTE, BYTE_TEXT, 5'd0);
        repeat (n) send(CMD_BYTE, plain_byte(1'b1), 5'($urandom_range(0, 31)));
        send(CMD_BYTE, BYTE_END, 5'd0);
        repeat ($urandom_range(1, 6))
          send(CMD_READ, 8'($urandom_range(0, 255)),
               5'($urandom_range(0, 3) == 0 ? $urandom_range(0, 31) : $urandom_range(0, 19)));
      end else if (kind < 65) begin
        // run of display characters, sometimes long enough to wrap the line
        repeat ($urandom_range(1, 25))
          send(CMD_BYTE, plain_byte(1'b0), 5'($urandom_range(0, 31)));
      end else if (kind < 73) begin
        send(CMD_BYTE, 8'($urandom_range(0, TONE_MAX)), 5'($urandom_range(0, 31)));
      end else if (kind < 78) begin
        send(CMD_BYTE, BYTE_CLEAR, 5'($urandom_range(0, 31)));
      end else if (kind < 88) begin
        repeat ($urandom_range(1, 20)) send(CMD_TICK, 8'($urandom_range(0, 255)), 5'd0);
      end else if (kind < 94) begin
        // broken sequence: a setting or capture cut short by any byte
        send(CMD_BYTE, $urandom_range(0, 1) ? BYTE_CLOCK : BYTE_TEXT, 5'd0);
        repeat ($urandom_range(0, 5)) send(CMD_BYTE, plain_byte(1'b0), 5'd0);
        send(CMD_BYTE, 8'($urandom_range(0, 255)), 5'($urandom_range(0, 31)));
      end else begin
        // noise: any command, any payload
        repeat ($urandom_range(1, 4))
          send(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
               5'($urandom_range(0, 31)));
      end
      if ($urandom_range(0, 39) == 0) drain();
    end

    // let everything come out, then wait for stray words
    drain();
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
